// ----- src/glc_pkg.sv -----
package glc_pkg;

  localparam int MaxVariants = 256;
  localparam int MaxClusters = 64;
  localparam int AlleleBits  = 8;

  localparam int PosBits   = $clog2(MaxVariants);
  localparam int LenBits   = $clog2(MaxVariants + 1);
  localparam int IdxBits   = $clog2(MaxClusters);
  localparam int CountBits = $clog2(MaxClusters + 1);
  localparam int ThrBits   = 17;
  localparam int LimitBits = ThrBits + LenBits;

  localparam logic [1:0] RegThreshold = 2'd0;
  localparam logic [1:0] RegImpute    = 2'd1;
  localparam logic [1:0] RegLength    = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic                  valid;
    logic                  first;
    logic                  last;
    logic                  scored;
    logic [PosBits-1:0]    pos;
    logic [AlleleBits-1:0] allele;
    logic                  found;
    logic [IdxBits-1:0]    idx;
  } word_t;

endpackage

// ----- src/glc_cell.sv -----
module glc_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [glc_pkg::IdxBits-1:0]   cell_id,
  input  logic [glc_pkg::CountBits-1:0] cluster_count,
  input  logic [glc_pkg::LimitBits-1:0] limit,
  input  glc_pkg::word_t                word_in,
  output glc_pkg::word_t                word_out
);

  logic [glc_pkg::AlleleBits-1:0] mem [glc_pkg::MaxVariants];
  logic [glc_pkg::AlleleBits-1:0] rd_data;
  glc_pkg::word_t                 stage;
  logic [glc_pkg::LenBits-1:0]    mismatches;
  logic [glc_pkg::LenBits-1:0]    total;
  logic                           active;
  logic                           target;
  logic                           match;

  assign active = {1'b0, cell_id} < cluster_count;
  assign target = {1'b0, cell_id} == cluster_count;

  always_ff @(posedge clk) begin
    if (word_in.valid && target) begin
      mem[word_in.pos] <= word_in.allele;
    end
    rd_data <= mem[word_in.pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else begin
      stage <= word_in;
    end
    if (stage.valid) begin
      mismatches <= total;
    end
  end

  always_comb begin
    total = (stage.first ? '0 : mismatches)
          + {{(glc_pkg::LenBits-1){1'b0}}, (stage.scored && (rd_data != stage.allele))};
    match = {{(glc_pkg::LimitBits-glc_pkg::LenBits-16){1'b0}}, total, 16'd0} <= limit;
    word_out = stage;
    if (stage.valid && stage.last && !stage.found && active && match) begin
      word_out.found = 1'b1;
      word_out.idx   = cell_id;
    end
  end

endmodule

// ----- src/genotype_leader_clustering.sv -----
// a call that does not end a sample gives no result
// a skipped sample gives its result in the cycle after its last call
// a kept sample gives its result after its last call once the profile has been read and all
// 256 profile entries have passed down the 64-cell chain, one per cycle, through each cell
// busy is high meanwhile; the next call can be taken in the cycle its result shows
// reset (synchronous, rst high) clears control state; results cannot be stalled
module genotype_leader_clustering (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [8:0]           first_allele,
  input  logic signed [8:0]           second_allele,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [glc_pkg::ThrBits-1:0] cfg_data,
  output logic                        done,
  output logic                        sample_skipped,
  output logic [5:0]                  cluster_index,
  output logic                        new_cluster,
  output logic                        table_full
);

  localparam int NC = glc_pkg::MaxClusters;

  glc_pkg::state_t state, state_next;

  logic [glc_pkg::ThrBits-1:0]    diff_threshold;
  logic                           impute_missing;
  logic [8:0]                     variants_per_sample;
  logic [glc_pkg::LenBits-1:0]    len;
  logic [glc_pkg::LimitBits-1:0]  limit;
  logic [glc_pkg::PosBits-1:0]    call_position;
  logic                           sample_invalid;
  logic [glc_pkg::CountBits-1:0]  cluster_count;
  logic [glc_pkg::AlleleBits-1:0] pmem [glc_pkg::MaxVariants];
  logic [glc_pkg::AlleleBits-1:0] prof_rd;
  logic [glc_pkg::PosBits-1:0]    sweep_pos;
  logic                           sweep_last;
  logic                           iss_valid;
  logic                           iss_last;
  logic                           iss_scored;
  logic [glc_pkg::PosBits-1:0]    iss_pos;
  logic                           sweeping;
  logic                           accept;
  logic                           miss;
  logic                           bad;
  logic                           call_last;
  logic [glc_pkg::AlleleBits-1:0] allele;
  logic                           chain_done;
  glc_pkg::word_t                 chain [NC+1];

  assign cfg_ready = !busy;

  always_comb begin
    if (variants_per_sample == 9'd0) begin
      len = glc_pkg::LenBits'(1);
    end else if ({1'b0, variants_per_sample} > 10'(glc_pkg::MaxVariants)) begin
      len = glc_pkg::LenBits'(glc_pkg::MaxVariants);
    end else begin
      len = glc_pkg::LenBits'(variants_per_sample);
    end
  end

  assign accept    = start && !busy;
  assign miss      = first_allele[8] || second_allele[8];
  assign bad       = miss ? !impute_missing : (first_allele != second_allele);
  assign allele    = miss ? '0 : first_allele[glc_pkg::AlleleBits-1:0];
  assign call_last = ({1'b0, call_position} + glc_pkg::LenBits'(1)) >= len;
  assign sweep_last = sweep_pos == glc_pkg::PosBits'(glc_pkg::MaxVariants - 1);
  assign chain_done = chain[NC].valid && chain[NC].last;

  always_comb begin
    state_next = state;
    case (state)
      glc_pkg::S_IDLE: begin
        if (accept && call_last && !(sample_invalid || bad)) begin
          state_next = glc_pkg::S_SWEEP;
        end
      end
      glc_pkg::S_SWEEP: begin
        if (sweep_last) begin
          state_next = glc_pkg::S_DRAIN;
        end
      end
      glc_pkg::S_DRAIN: begin
        if (chain_done) begin
          state_next = glc_pkg::S_IDLE;
        end
      end
      default: state_next = glc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b1;
    sweeping = 1'b0;
    case (state)
      glc_pkg::S_IDLE:  busy = 1'b0;
      glc_pkg::S_SWEEP: sweeping = 1'b1;
      glc_pkg::S_DRAIN: busy = 1'b1;
      default:          busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= glc_pkg::S_IDLE;
      diff_threshold      <= '0;
      impute_missing      <= 1'b0;
      variants_per_sample <= 9'd1;
      call_position       <= '0;
      sample_invalid      <= 1'b0;
      cluster_count       <= '0;
      sweep_pos           <= '0;
      iss_valid           <= 1'b0;
      done                <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          glc_pkg::RegThreshold: diff_threshold <= cfg_data;
          glc_pkg::RegImpute:    impute_missing <= cfg_data[0];
          glc_pkg::RegLength:    variants_per_sample <= cfg_data[8:0];
          default: ;
        endcase
      end
      iss_valid <= sweeping;
      done      <= 1'b0;
      if (accept) begin
        if (call_last) begin
          call_position  <= '0;
          sample_invalid <= 1'b0;
          sweep_pos      <= '0;
          if (sample_invalid || bad) begin
            done           <= 1'b1;
            sample_skipped <= 1'b1;
            cluster_index  <= '0;
            new_cluster    <= 1'b0;
            table_full     <= 1'b0;
          end
        end else begin
          call_position  <= call_position + 1'b1;
          sample_invalid <= sample_invalid || bad;
        end
      end
      if (sweeping) begin
        sweep_pos <= sweep_pos + 1'b1;
      end
      if (chain_done) begin
        done           <= 1'b1;
        sample_skipped <= 1'b0;
        if (chain[NC].found) begin
          cluster_index <= chain[NC].idx;
          new_cluster   <= 1'b0;
          table_full    <= 1'b0;
        end else if (cluster_count >= glc_pkg::CountBits'(NC)) begin
          cluster_index <= '0;
          new_cluster   <= 1'b0;
          table_full    <= 1'b1;
        end else begin
          cluster_index <= cluster_count[glc_pkg::IdxBits-1:0];
          new_cluster   <= 1'b1;
          table_full    <= 1'b0;
          cluster_count <= cluster_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pmem[call_position] <= allele;
    end
    prof_rd    <= pmem[sweep_pos];
    iss_pos    <= sweep_pos;
    iss_last   <= sweep_last;
    iss_scored <= {1'b0, sweep_pos} < len;
    limit      <= {{glc_pkg::LenBits{1'b0}}, diff_threshold}
                * {{glc_pkg::ThrBits{1'b0}}, len};
  end

  always_comb begin
    chain[0].valid  = iss_valid;
    chain[0].first  = iss_pos == '0;
    chain[0].last   = iss_last;
    chain[0].scored = iss_scored;
    chain[0].pos    = iss_pos;
    chain[0].allele = prof_rd;
    chain[0].found  = 1'b0;
    chain[0].idx    = '0;
  end

  for (genvar i = 0; i < NC; i++) begin : g_cell
    glc_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .cell_id       (glc_pkg::IdxBits'(i)),
      .cluster_count (cluster_count),
      .limit         (limit),
      .word_in       (chain[i]),
      .word_out      (chain[i+1])
    );
  end

endmodule

// ----- src/glc_checker.sv -----
module glc_checker (
  input logic       clk,
  input logic       rst,
  input logic       busy,
  input logic       done,
  input logic       sample_skipped,
  input logic [5:0] cluster_index,
  input logic       new_cluster,
  input logic       table_full
);

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot0({sample_skipped, new_cluster, table_full}))
    else $error("result flags overlap");

  a_skip_clean: assert property (@(posedge clk) disable iff (rst)
    done && sample_skipped |-> cluster_index == 6'd0)
    else $error("skipped word carries an index");

  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    done && table_full |-> cluster_index == 6'd0)
    else $error("full word carries an index");

  a_sweep_quiet: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> !done)
    else $error("word emitted as sweep begins");

endmodule

bind genotype_leader_clustering glc_checker u_glc_checker (
  .clk            (clk),
  .rst            (rst),
  .busy           (busy),
  .done           (done),
  .sample_skipped (sample_skipped),
  .cluster_index  (cluster_index),
  .new_cluster    (new_cluster),
  .table_full     (table_full)
);

// ----- dv/genotype_leader_clustering_tb.sv -----
`timescale 1ns / 1ps

module genotype_leader_clustering_tb;

  typedef struct {
    logic       skipped;
    logic [5:0] index;
    logic       founded;
    logic       full;
  } verdict_t;

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        busy;
  logic signed [8:0]           first_allele;
  logic signed [8:0]           second_allele;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [1:0]                  cfg_index;
  logic [glc_pkg::ThrBits-1:0] cfg_data;
  logic                        done;
  logic                        sample_skipped;
  logic [5:0]                  cluster_index;
  logic                        new_cluster;
  logic                        table_full;

  // clustering state mirrored by the predictor
  logic [16:0]          thr_q16;
  logic                 impute_on;
  logic [8:0]           length_reg;
  logic [7:0]           profile [glc_pkg::MaxVariants];
  logic [7:0]           leaders [glc_pkg::MaxClusters][glc_pkg::MaxVariants];
  int                   leader_count;
  int                   call_pos;
  logic                 sample_bad;

  verdict_t             pending_verdicts[$];
  int                   errors;
  logic                 quiet;

  genotype_leader_clustering uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .first_allele   (first_allele),
    .second_allele  (second_allele),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .sample_skipped (sample_skipped),
    .cluster_index  (cluster_index),
    .new_cluster    (new_cluster),
    .table_full     (table_full)
  );

  always #10 clk = ~clk;

  task automatic report(input string what, input int got, input int want);
    $display("error: %s got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic void log_verdict(input verdict_t v);
    pending_verdicts = {pending_verdicts, v};
  endfunction

  function automatic int active_len();
    if (length_reg == 0) return 1;
    if (length_reg > glc_pkg::MaxVariants) return glc_pkg::MaxVariants;
    return int'(length_reg);
  endfunction

  task automatic classify_call(input logic signed [8:0] a, input logic signed [8:0] b);
    logic [7:0]     st;
    int             len;
    int             diffs;
    verdict_t       v;
    longint unsigned lhs;
    longint unsigned rhs;
    st = 8'd0;
    len = active_len();
    if (a[8] || b[8]) begin
      if (!impute_on) sample_bad = 1'b1;
    end else if (a != b) begin
      sample_bad = 1'b1;
    end else begin
      st = a[7:0];
    end
    profile[call_pos] = st;
    if (call_pos + 1 < len) begin
      call_pos++;
      return;
    end
    call_pos = 0;
    v = '{1'b0, 6'd0, 1'b0, 1'b0};
    if (sample_bad) begin
      sample_bad = 1'b0;
      v.skipped = 1'b1;
      log_verdict(v);
      return;
    end
    for (int r = 0; r < leader_count; r++) begin
      diffs = 0;
      for (int i = 0; i < len; i++) if (leaders[r][i] != profile[i]) diffs++;
      lhs = longint'(diffs) * 65536;
      rhs = longint'(thr_q16) * longint'(len);
      if (lhs <= rhs) begin
        v.index = r[5:0];
        log_verdict(v);
        return;
      end
    end
    if (leader_count >= glc_pkg::MaxClusters) begin
      v.full = 1'b1;
    end else begin
      for (int i = 0; i < glc_pkg::MaxVariants; i++) leaders[leader_count][i] = profile[i];
      v.index = leader_count[5:0];
      v.founded = 1'b1;
      leader_count++;
    end
    log_verdict(v);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_verdicts.size() == 0) begin
        report("unexpected word", 1, 0);
      end else begin
        verdict_t v;
        v = pending_verdicts.pop_front();
        if (sample_skipped != v.skipped)
          report("sample_skipped", int'(sample_skipped), int'(v.skipped));
        if (cluster_index != v.index)
          report("cluster_index", int'(cluster_index), int'(v.index));
        if (new_cluster != v.founded)
          report("new_cluster", int'(new_cluster), int'(v.founded));
        if (table_full != v.full)
          report("table_full", int'(table_full), int'(v.full));
      end
    end
  end

  task automatic send_call(input logic signed [8:0] a, input logic signed [8:0] b);
    if (!quiet && $urandom_range(99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    first_allele <= a;
    second_allele <= b;
    do @(posedge clk); while (busy);
    classify_call(a, b);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    if (!quiet && $urandom_range(99) < 8) repeat ($urandom_range(1, 4)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[glc_pkg::ThrBits-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      glc_pkg::RegThreshold: thr_q16 = val[16:0];
      glc_pkg::RegImpute:    impute_on = val[0];
      glc_pkg::RegLength:    length_reg = val[8:0];
      default: ;
    endcase
  endtask

  task automatic send_sample(input int len, input int pool);
    logic signed [8:0] a;
    logic signed [8:0] b;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 10) begin
        a = 9'($urandom);
        b = 9'($urandom);
      end else begin
        a = (pool > 0) ? 9'($urandom_range(0, pool)) : 9'($urandom_range(0, 255));
        if (impute_on && $urandom_range(99) < 5) a = -9'sd1;
        b = a;
      end
      send_call(a, b);
    end
  endtask

  task automatic test_longest_profile();
    write_reg(glc_pkg::RegThreshold, 0);
    write_reg(glc_pkg::RegImpute, 0);
    write_reg(glc_pkg::RegLength, 511);
    for (int i = 0; i < glc_pkg::MaxVariants; i++) begin
      logic signed [8:0] v;
      v = 9'($urandom_range(0, 1));
      send_call(v, v);
    end
    settle();
    write_reg(glc_pkg::RegLength, glc_pkg::MaxVariants);
  endtask

  task automatic test_call_kinds();
    settle();
    write_reg(glc_pkg::RegLength, 4);
    repeat (4) send_call(9'sd255, 9'sd255);
    repeat (4) send_call(9'sd0, 9'sd0);
    send_call(9'sd1, 9'sd1);
    send_call(9'sd1, 9'sd2);
    send_call(9'sd3, 9'sd3);
    send_call(9'sd3, 9'sd3);
    send_call(-9'sd1, -9'sd1);
    repeat (3) send_call(9'sd0, 9'sd0);
    settle();
    write_reg(glc_pkg::RegImpute, 1);
    send_call(-9'sd1, 9'sd5);
    send_call(-9'sd256, -9'sd1);
    send_call(9'sd0, -9'sd256);
    send_call(9'sd255, 9'sd255);
    // shrink the profile length partway through a sample
    send_call(9'sd7, 9'sd7);
    send_call(9'sd7, 9'sd7);
    settle();
    write_reg(glc_pkg::RegLength, 2);
    send_call(9'sd7, 9'sd7);
    settle();
  endtask

  task automatic test_random_profiles();
    int lens [3] = '{8, 6, 3};
    quiet = 1'b1;
    for (int p = 0; p < 3; p++) begin
      write_reg(glc_pkg::RegLength, lens[p]);
      write_reg(glc_pkg::RegThreshold, (p == 1) ? 65536 : $urandom_range(0, 65536));
      write_reg(glc_pkg::RegImpute, $urandom_range(0, 1));
      for (int n = 0; n < 84 / lens[p]; n++) begin
        if (n == 5) quiet = 1'b0;
        send_sample(lens[p], (n % 3 == 0) ? 0 : 2);
      end
      settle();
    end
  endtask

  task automatic test_table_full();
    write_reg(glc_pkg::RegLength, 0);
    write_reg(glc_pkg::RegThreshold, 0);
    write_reg(glc_pkg::RegImpute, 1);
    repeat (120) send_sample(1, 0);
    settle();
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    first_allele = '0;
    second_allele = '0;
    cfg_valid = 1'b0;
    cfg_index = glc_pkg::RegThreshold;
    cfg_data = '0;
    thr_q16 = '0;
    impute_on = 1'b0;
    length_reg = 9'd1;
    leader_count = 0;
    call_pos = 0;
    sample_bad = 1'b0;
    errors = 0;
    quiet = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_longest_profile();
    test_call_kinds();
    test_random_profiles();
    test_table_full();
    repeat (300) @(posedge clk);
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("genotype_leader_clustering: match");
    end else begin
      $display("genotype_leader_clustering: mismatch");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("genotype_leader_clustering: mismatch");
    $finish;
  end

endmodule
